// ===== sv/hcb_pkg.sv =====
// Shared package for the Huffman code builder.
// Holds field widths, default sizing, the sequencer states and memory controls.
// No dependencies.
package hcb_pkg;

  // Default sizing of the block
  localparam int HCB_MAX_SYMBOLS = 32;
  localparam int HCB_WEIGHT_BITS = 16;

  // Fixed port field widths
  localparam int WEIGHT_W = 16;
  localparam int SYMBOL_W = 5;
  localparam int CODE_W   = 31;
  localparam int LENGTH_W = 5;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_TAIL,
    ST_MERGE_L,
    ST_MERGE_R,
    ST_WALK,
    ST_WALK_PAR,
    ST_WALK_LEFT,
    ST_OUT
  } hcb_state_t;

  // Write strobes toward the tree memories
  typedef struct packed {
    logic wt_we;
    logic par_we;
    logic left_we;
  } hcb_mem_we_t;

endpackage

// ===== sv/hcb_tree_mem.sv =====
// Tree storage: node weights, node parents and left children of merged nodes.
// One write and one registered read port per memory.
// Depends on hcb_pkg.
module hcb_tree_mem #(
  parameter int MAX_SYMBOLS = hcb_pkg::HCB_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::HCB_WEIGHT_BITS,
  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1,
  localparam int NODE_BITS  = $clog2(NODE_COUNT),
  localparam int LEAF_BITS  = (WEIGHT_BITS < hcb_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                                : hcb_pkg::WEIGHT_W,
  localparam int SUM_BITS   = LEAF_BITS + $clog2(MAX_SYMBOLS),
  localparam int LEFT_DEPTH = MAX_SYMBOLS - 1,
  localparam int LEFT_BITS  = (MAX_SYMBOLS > 2) ? $clog2(LEFT_DEPTH) : 1
) (
  input  logic                clk,
  input  hcb_pkg::hcb_mem_we_t we,
  input  logic [NODE_BITS-1:0] wt_waddr,
  input  logic [SUM_BITS-1:0]  wt_wdata,
  input  logic [NODE_BITS-1:0] wt_raddr,
  output logic [SUM_BITS-1:0]  wt_rdata,
  input  logic [NODE_BITS-1:0] par_waddr,
  input  logic [NODE_BITS-1:0] par_wdata,
  input  logic [NODE_BITS-1:0] par_raddr,
  output logic [NODE_BITS-1:0] par_rdata,
  input  logic [LEFT_BITS-1:0] left_waddr,
  input  logic [NODE_BITS-1:0] left_wdata,
  input  logic [LEFT_BITS-1:0] left_raddr,
  output logic [NODE_BITS-1:0] left_rdata
);

  logic [SUM_BITS-1:0]  wt_mem   [NODE_COUNT];
  logic [NODE_BITS-1:0] par_mem  [NODE_COUNT];
  logic [NODE_BITS-1:0] left_mem [LEFT_DEPTH];

  // Weight memory
  always_ff @(posedge clk) begin
    if (we.wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata <= wt_mem[wt_raddr];
  end

  // Parent memory
  always_ff @(posedge clk) begin
    if (we.par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= par_mem[par_raddr];
  end

  // Left child memory
  always_ff @(posedge clk) begin
    if (we.left_we) begin
      left_mem[left_waddr] <= left_wdata;
    end
    left_rdata <= left_mem[left_raddr];
  end

endmodule

// ===== sv/hcb_min_select.sv =====
// Shared compare unit: tracks the two lowest-weight parentless nodes of a scan.
// Ties keep the earlier (lower) index; also forms the sum of the pair.
// Depends on hcb_pkg.
module hcb_min_select #(
  parameter int MAX_SYMBOLS = hcb_pkg::HCB_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::HCB_WEIGHT_BITS,
  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1,
  localparam int NODE_BITS  = $clog2(NODE_COUNT),
  localparam int LEAF_BITS  = (WEIGHT_BITS < hcb_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                                : hcb_pkg::WEIGHT_W,
  localparam int SUM_BITS   = LEAF_BITS + $clog2(MAX_SYMBOLS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 load,
  input  logic                 free,
  input  logic [NODE_BITS-1:0] node,
  input  logic [SUM_BITS-1:0]  wgt,
  output logic [NODE_BITS-1:0] pick_lo,
  output logic [NODE_BITS-1:0] pick_hi,
  output logic [SUM_BITS-1:0]  pair_sum
);

  logic                found_lo;
  logic                found_hi;
  logic [SUM_BITS-1:0] min_lo;
  logic [SUM_BITS-1:0] min_hi;
  logic                below_lo;
  logic                below_hi;

  // Strict less-than keeps the lower index on a tie
  assign below_lo = !found_lo || (wgt < min_lo);
  assign below_hi = !found_hi || (wgt < min_hi);
  assign pair_sum = min_lo + min_hi;

  // Update found flags
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found_lo <= 1'b0;
      found_hi <= 1'b0;
    end else if (load && free) begin
      if (below_lo) begin
        found_lo <= 1'b1;
        found_hi <= found_lo;
      end else if (below_hi) begin
        found_hi <= 1'b1;
      end
    end
  end

  // Update the two running minima
  always_ff @(posedge clk) begin
    if (load && free) begin
      if (below_lo) begin
        min_hi  <= min_lo;
        pick_hi <= pick_lo;
        min_lo  <= wgt;
        pick_lo <= node;
      end else if (below_hi) begin
        min_hi  <= wgt;
        pick_hi <= node;
      end
    end
  end

  a_hi_needs_lo : assert property (@(posedge clk) disable iff (rst)
    found_hi |-> found_lo)
    else $error("second minimum found without a first");

  a_order : assert property (@(posedge clk) disable iff (rst)
    found_lo && found_hi |-> min_lo <= min_hi)
    else $error("minima out of order");

  a_distinct : assert property (@(posedge clk) disable iff (rst)
    found_lo && found_hi |-> pick_lo != pick_hi)
    else $error("same node picked twice");

endmodule

// ===== sv/huffman_code_builder.sv =====
// Huffman code builder: loads one weight per cycle while idle; the request with last set
// starts a sweep that clears all 2n-1 parent entries, then merge k (k = 0..n-2) scans nodes
// 0..n+k-1 on the shared compare unit, then each symbol walks up its parents in the memories.
// Results appear one per strobe cycle, in symbol order, and cannot be stalled.
// Synchronous reset returns to idle with an empty symbol set.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = hcb_pkg::HCB_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::HCB_WEIGHT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [hcb_pkg::WEIGHT_W-1:0] weight,
  input  logic                         last,
  output logic                         strobe,
  output logic [hcb_pkg::SYMBOL_W-1:0] symbol,
  output logic [hcb_pkg::CODE_W-1:0]   code,
  output logic [hcb_pkg::LENGTH_W-1:0] code_length,
  output logic                         final_res
);

  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int LEAF_BITS  = (WEIGHT_BITS < hcb_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                                : hcb_pkg::WEIGHT_W;
  localparam int SUM_BITS   = LEAF_BITS + $clog2(MAX_SYMBOLS);
  localparam int LEFT_BITS  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS - 1) : 1;
  localparam int CNT_BITS   = $clog2(MAX_SYMBOLS + 1);
  localparam int LEN_BITS   = $clog2(MAX_SYMBOLS);
  localparam logic [NODE_BITS-1:0] NO_PARENT = '1;

  hcb_pkg::hcb_state_t state;
  hcb_pkg::hcb_state_t state_next;

  logic [CNT_BITS-1:0]         count;
  logic [CNT_BITS-1:0]         sym;
  logic [NODE_BITS-1:0]        idx;
  logic [NODE_BITS-1:0]        merged;
  logic                        rd_vld;
  logic [NODE_BITS-1:0]        rd_idx;
  logic [NODE_BITS-1:0]        cur;
  logic [NODE_BITS-1:0]        par;
  logic [LEN_BITS-1:0]         len;
  logic [hcb_pkg::CODE_W-1:0]  code_r;

  logic                        accept;
  logic [NODE_BITS-1:0]        node_n;
  logic [NODE_BITS-1:0]        last_node;
  logic                        last_sym;

  hcb_pkg::hcb_mem_we_t        mem_we;
  logic [NODE_BITS-1:0]        wt_waddr;
  logic [SUM_BITS-1:0]         wt_wdata;
  logic [SUM_BITS-1:0]         wt_rdata;
  logic [NODE_BITS-1:0]        par_waddr;
  logic [NODE_BITS-1:0]        par_wdata;
  logic [NODE_BITS-1:0]        par_raddr;
  logic [NODE_BITS-1:0]        par_rdata;
  logic [LEFT_BITS-1:0]        left_waddr;
  logic [LEFT_BITS-1:0]        left_raddr;
  logic [NODE_BITS-1:0]        left_rdata;

  logic                        min_clear;
  logic [NODE_BITS-1:0]        pick_lo;
  logic [NODE_BITS-1:0]        pick_hi;
  logic [SUM_BITS-1:0]         pair_sum;

  assign busy      = (state != hcb_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign node_n    = NODE_BITS'(count);
  assign last_node = (node_n << 1) - NODE_BITS'(2);
  assign last_sym  = (sym == count - CNT_BITS'(1));

  // Drive the result ports from the walk registers
  assign strobe      = (state == hcb_pkg::ST_OUT);
  assign symbol      = hcb_pkg::SYMBOL_W'(sym);
  assign code        = code_r;
  assign code_length = hcb_pkg::LENGTH_W'(len);
  assign final_res   = strobe && last_sym;

  // Memory address and data selection
  assign wt_wdata   = (state == hcb_pkg::ST_IDLE) ? SUM_BITS'(weight[LEAF_BITS-1:0])
                                                  : pair_sum;
  assign wt_waddr   = (state == hcb_pkg::ST_IDLE) ? node_n : merged;
  assign left_waddr = LEFT_BITS'(merged - node_n);
  assign left_raddr = LEFT_BITS'(par_rdata - node_n);
  assign min_clear  = (state == hcb_pkg::ST_CLEAR) || (state == hcb_pkg::ST_MERGE_R);

  always_comb begin
    unique case (state)
      hcb_pkg::ST_CLEAR:     par_waddr = idx;
      hcb_pkg::ST_MERGE_L:   par_waddr = pick_lo;
      default:               par_waddr = pick_hi;
    endcase
    par_wdata = (state == hcb_pkg::ST_CLEAR) ? NO_PARENT : merged;
    unique case (state)
      hcb_pkg::ST_WALK:      par_raddr = NODE_BITS'(sym);
      hcb_pkg::ST_WALK_LEFT: par_raddr = par;
      default:               par_raddr = idx;
    endcase
  end

  // Next state and memory write strobes
  always_comb begin
    state_next     = state;
    mem_we.wt_we   = 1'b0;
    mem_we.par_we  = 1'b0;
    mem_we.left_we = 1'b0;
    unique case (state)
      hcb_pkg::ST_IDLE: begin
        mem_we.wt_we = accept && (count < CNT_BITS'(MAX_SYMBOLS));
        if (accept && last) begin
          state_next = hcb_pkg::ST_CLEAR;
        end
      end
      hcb_pkg::ST_CLEAR: begin
        mem_we.par_we = 1'b1;
        if (idx == last_node) begin
          state_next = (count == CNT_BITS'(1)) ? hcb_pkg::ST_WALK : hcb_pkg::ST_SCAN;
        end
      end
      hcb_pkg::ST_SCAN: begin
        if (idx == merged - NODE_BITS'(1)) begin
          state_next = hcb_pkg::ST_TAIL;
        end
      end
      hcb_pkg::ST_TAIL: begin
        state_next = hcb_pkg::ST_MERGE_L;
      end
      hcb_pkg::ST_MERGE_L: begin
        mem_we.wt_we   = 1'b1;
        mem_we.par_we  = 1'b1;
        mem_we.left_we = 1'b1;
        state_next     = hcb_pkg::ST_MERGE_R;
      end
      hcb_pkg::ST_MERGE_R: begin
        mem_we.par_we = 1'b1;
        state_next = (merged == last_node) ? hcb_pkg::ST_WALK : hcb_pkg::ST_SCAN;
      end
      hcb_pkg::ST_WALK: begin
        state_next = hcb_pkg::ST_WALK_PAR;
      end
      hcb_pkg::ST_WALK_PAR: begin
        state_next = (par_rdata == NO_PARENT) ? hcb_pkg::ST_OUT : hcb_pkg::ST_WALK_LEFT;
      end
      hcb_pkg::ST_WALK_LEFT: begin
        state_next = hcb_pkg::ST_WALK_PAR;
      end
      hcb_pkg::ST_OUT: begin
        state_next = last_sym ? hcb_pkg::ST_IDLE : hcb_pkg::ST_WALK;
      end
      default: begin
        state_next = hcb_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Symbol count: advance on each held weight, drop after the last result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (mem_we.wt_we && state == hcb_pkg::ST_IDLE) begin
      count <= count + CNT_BITS'(1);
    end else if (strobe && last_sym) begin
      count <= '0;
    end
  end

  // Scan read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == hcb_pkg::ST_SCAN);
    end
    rd_idx <= idx;
  end

  // Sweep, scan and walk counters
  always_ff @(posedge clk) begin
    unique case (state)
      hcb_pkg::ST_IDLE: begin
        idx    <= '0;
        merged <= '0;
        sym    <= '0;
      end
      hcb_pkg::ST_CLEAR: begin
        idx    <= (idx == last_node) ? '0 : idx + NODE_BITS'(1);
        merged <= node_n;
      end
      hcb_pkg::ST_SCAN: begin
        idx <= idx + NODE_BITS'(1);
      end
      hcb_pkg::ST_MERGE_R: begin
        idx    <= '0;
        merged <= merged + NODE_BITS'(1);
      end
      hcb_pkg::ST_WALK: begin
        cur    <= NODE_BITS'(sym);
        len    <= '0;
        code_r <= '0;
      end
      hcb_pkg::ST_WALK_PAR: begin
        par <= par_rdata;
      end
      hcb_pkg::ST_WALK_LEFT: begin
        // A right child sets its bit at the current depth
        if (left_rdata != cur) begin
          code_r <= code_r | (hcb_pkg::CODE_W'(1) << len);
        end
        len <= len + LEN_BITS'(1);
        cur <= par;
      end
      hcb_pkg::ST_OUT: begin
        sym <= sym + CNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  hcb_tree_mem #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .wt_waddr  (wt_waddr),
    .wt_wdata  (wt_wdata),
    .wt_raddr  (idx),
    .wt_rdata  (wt_rdata),
    .par_waddr (par_waddr),
    .par_wdata (par_wdata),
    .par_raddr (par_raddr),
    .par_rdata (par_rdata),
    .left_waddr(left_waddr),
    .left_wdata(pick_lo),
    .left_raddr(left_raddr),
    .left_rdata(left_rdata)
  );

  hcb_min_select #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_min (
    .clk     (clk),
    .rst     (rst),
    .clear   (min_clear),
    .load    (rd_vld),
    .free    (par_rdata == NO_PARENT),
    .node    (rd_idx),
    .wgt     (wt_rdata),
    .pick_lo (pick_lo),
    .pick_hi (pick_hi),
    .pair_sum(pair_sum)
  );

  a_close_goes_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy)
    else $error("closing request did not start a build");

  a_final_frees : assert property (@(posedge clk) disable iff (rst)
    strobe && final_res |=> !busy)
    else $error("block still busy after the final result");

  a_symbol_range : assert property (@(posedge clk) disable iff (rst)
    strobe |-> sym < count)
    else $error("result symbol beyond the loaded set");

endmodule
